// File: hdl/qte_pkg.sv
package qte_pkg;

    // Q4.28 products and sums of 16-bit inputs: |value| < 2^35.
    localparam int SUM_W   = 36;
    // CORDIC x/y: x may grow by the CORDIC gain (about 1.65) after the left-half fold.
    localparam int VEC_W   = 38;
    localparam int ACC_W   = 32;
    localparam int TAB_LEN = 24;
    localparam int SQ_IN_W = 58;
    localparam int SQ_OUT_W = 29;

    localparam logic signed [SUM_W-1:0] Q_ONE = 36'sd268435456;
    localparam logic signed [ACC_W-1:0] HALF_TURN = 32'sd754974720;
    localparam logic signed [15:0] ROLL_YAW_LIMIT = 16'sd11520;
    localparam logic signed [15:0] PITCH_LIMIT = 16'sd5760;

    typedef struct packed {
        logic signed [SUM_W-1:0] sinr;
        logic signed [SUM_W-1:0] cosr;
        logic signed [SUM_W-1:0] sinp;
        logic signed [SUM_W-1:0] siny;
        logic signed [SUM_W-1:0] cosy;
        logic                    clamped;
    } qte_front_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ACC_W-1:0] acc;
        logic                    zero;
    } qte_cordic_t;

    function automatic logic signed [ACC_W-1:0] atan_tab(input int i);
        logic signed [ACC_W-1:0] t;
        begin
            unique case (i)
                0: t = 32'sd188743680;
                1: t = 32'sd111421900;
                2: t = 32'sd58872272;
                3: t = 32'sd29884485;
                4: t = 32'sd15000234;
                5: t = 32'sd7507429;
                6: t = 32'sd3754631;
                7: t = 32'sd1877430;
                8: t = 32'sd938729;
                9: t = 32'sd469366;
                10: t = 32'sd234683;
                11: t = 32'sd117342;
                12: t = 32'sd58671;
                13: t = 32'sd29335;
                14: t = 32'sd14668;
                15: t = 32'sd7334;
                16: t = 32'sd3667;
                17: t = 32'sd1833;
                18: t = 32'sd917;
                19: t = 32'sd458;
                20: t = 32'sd229;
                21: t = 32'sd115;
                22: t = 32'sd57;
                23: t = 32'sd29;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

    // Seed one CORDIC lane: left-half fold and zero detection.
    function automatic qte_cordic_t cordic_seed(input logic signed [SUM_W-1:0] num,
                                                input logic signed [SUM_W-1:0] den);
        qte_cordic_t c;
        begin
            c.zero = (num == '0) && (den == '0);
            if (den < 0)
            begin
                c.x = -VEC_W'(den);
                c.y = -VEC_W'(num);
                c.acc = (num >= 0) ? HALF_TURN : -HALF_TURN;
            end
            else
            begin
                c.x = VEC_W'(den);
                c.y = VEC_W'(num);
                c.acc = '0;
            end
            return c;
        end
    endfunction

    function automatic qte_cordic_t cordic_iter(input qte_cordic_t c, input int i);
        qte_cordic_t n;
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        begin
            n = c;
            xs = c.x >>> i;
            ys = c.y >>> i;
            if (c.y >= 0)
            begin
                n.x = c.x + ys;
                n.y = c.y - xs;
                n.acc = c.acc + atan_tab(i);
            end
            else
            begin
                n.x = c.x - ys;
                n.y = c.y + xs;
                n.acc = c.acc - atan_tab(i);
            end
            return n;
        end
    endfunction

    function automatic logic signed [15:0] cordic_final(input qte_cordic_t c,
                                                        input logic signed [15:0] lim);
        logic signed [ACC_W:0] r;
        begin
            r = ((ACC_W+1)'(c.acc) + (ACC_W+1)'(32768)) >>> 16;
            if (c.zero)
                return '0;
            if (r > (ACC_W+1)'(lim))
                return lim;
            if (r < -(ACC_W+1)'(lim))
                return -lim;
            return 16'(r);
        end
    endfunction

endpackage

// File: hdl/quaternion_to_euler_angles.sv
// Converts a stream of orientation quaternions (w, x, y, z, signed Q2.14) into
// ZYX Euler angles roll, pitch and yaw in units of 1/64 degree, plus a flag
// that is set when the pitch sine exceeded unit magnitude and was clamped.
// One transfer is accepted every clock cycle while the output does not stall,
// and results leave in input order. An input passes the registered product
// and sum stages of the front, the queue, the load stage of the back end, 29
// square-root stages, 1 seed stage, one micro-rotation stage per CORDIC step
// (CORDIC_STEPS, default 16; steps beyond 24 are not built) and 1 output
// register. The throughput of one item per cycle is set by the fully
// pipelined CORDIC and square-root stages.
// Back-pressure on the output stalls the pipeline without losing items.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: roll_angle [14:0], pitch_angle [28:15], yaw_angle [43:29],
    // pitch_clamped [44], zero [47:45]
    output logic [47:0] m_axis_tdata
);
    import qte_pkg::*;

    logic       f_valid;
    logic       f_ready;
    qte_front_t f_data;
    logic       q_valid;
    logic       q_ready;
    qte_front_t q_data;
    logic signed [14:0] roll;
    logic signed [13:0] pitch;
    logic signed [14:0] yaw;
    logic       clamped;

    qte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .w         (s_axis_tdata[15:0]),
        .x         (s_axis_tdata[31:16]),
        .y         (s_axis_tdata[47:32]),
        .z         (s_axis_tdata[63:48]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    // Short queue decoupling the front from the long back pipeline.
    qte_queue #(.WIDTH($bits(qte_front_t))) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    qte_back #(.STEPS(CORDIC_STEPS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .roll      (roll),
        .pitch     (pitch),
        .yaw       (yaw),
        .clamped   (clamped)
    );

    assign m_axis_tdata = {3'b000, clamped, yaw, pitch, roll};

endmodule

// File: hdl/qte_front.sv
// Front: forms the ZYX product sums over two registered stages and clamps the
// pitch argument.
module qte_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  w,
    input  logic signed [15:0]  x,
    input  logic signed [15:0]  y,
    input  logic signed [15:0]  z,
    output logic                out_valid,
    input  logic                out_ready,
    output qte_pkg::qte_front_t out_data
);
    import qte_pkg::*;

    logic signed [31:0] p_reg [10];
    logic               v1_reg;
    logic               v2_reg;
    qte_front_t         d2_reg;
    qte_front_t         d2_next;
    logic               adv2;
    logic               adv1;
    logic signed [SUM_W-1:0] sp;

    assign adv2 = !v2_reg || out_ready;
    assign adv1 = !v1_reg || adv2;
    assign in_ready = adv1;
    assign out_valid = v2_reg;
    assign out_data = d2_reg;

    always_comb
    begin
        d2_next.sinr = (SUM_W'(p_reg[0]) + SUM_W'(p_reg[1])) <<< 1;
        d2_next.cosr = Q_ONE - ((SUM_W'(p_reg[2]) + SUM_W'(p_reg[3])) <<< 1);
        sp = (SUM_W'(p_reg[4]) - SUM_W'(p_reg[5])) <<< 1;
        d2_next.siny = (SUM_W'(p_reg[6]) + SUM_W'(p_reg[7])) <<< 1;
        d2_next.cosy = Q_ONE - ((SUM_W'(p_reg[8]) + SUM_W'(p_reg[9])) <<< 1);
        d2_next.clamped = (sp > Q_ONE) || (sp < -Q_ONE);
        if (sp > Q_ONE)
            d2_next.sinp = Q_ONE;
        else if (sp < -Q_ONE)
            d2_next.sinp = -Q_ONE;
        else
            d2_next.sinp = sp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            p_reg[0] <= w * x;
            p_reg[1] <= y * z;
            p_reg[2] <= x * x;
            p_reg[3] <= y * y;
            p_reg[4] <= w * y;
            p_reg[5] <= z * x;
            p_reg[6] <= w * z;
            p_reg[7] <= x * y;
            p_reg[8] <= y * y;
            p_reg[9] <= z * z;
        end
        if (adv2 && v1_reg)
            d2_reg <= d2_next;
    end

endmodule

// File: hdl/qte_queue.sv
// Two-entry queue between front and back.
module qte_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg;
    logic             rp_reg;
    logic [1:0]       cnt_reg;
    logic             push;
    logic             pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2) else $error("queue count beyond depth");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("queue count did not drop on pop");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count did not rise on push");
`endif

endmodule

// File: hdl/qte_back.sv
// Back: pitch square root (one result bit per stage), then three CORDIC lanes,
// one micro-rotation per stage, then rounding and saturation.
module qte_back #(
    parameter int STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qte_pkg::qte_front_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [14:0]  roll,
    output logic signed [13:0]  pitch,
    output logic signed [14:0]  yaw,
    output logic                clamped
);
    import qte_pkg::*;

    localparam int NSTEP = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;
    localparam int SQS = SQ_OUT_W;
    localparam int NST = SQS + 1 + NSTEP + 1;

    typedef struct packed {
        logic [SQ_IN_W-1:0]    rem;
        logic [SQ_OUT_W-1:0]   root;
        qte_front_t            f;
        qte_cordic_t           r;
        qte_cordic_t           p;
        qte_cordic_t           yw;
    } stage_t;

    stage_t st_reg [NST];
    stage_t st_next [NST];
    logic   v_reg [NST];
    logic   adv [NST];
    logic   last_adv;

    // Stall chain: each stage moves when the one after it has room.
    always_comb
    begin
        adv[NST-1] = !v_reg[NST-1] || last_adv;
        for (int k = NST - 2; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
    end
    assign in_ready = adv[0];

    always_comb
    begin
        logic [SQ_IN_W-1:0]   trial;
        logic signed [71:0]   sq;
        for (int k = 0; k < NST; k++)
            st_next[k] = (k == 0) ? st_reg[0] : st_reg[k-1];
        // Stage 0: load and form 2^56 - s*s.
        sq = 72'(in_data.sinp) * 72'(in_data.sinp);
        st_next[0] = '0;
        st_next[0].f = in_data;
        st_next[0].rem = SQ_IN_W'((72'sd1 <<< 56) - sq);
        // Square root stages: bit SQS-k of the root.
        for (int k = 1; k <= SQS; k++)
        begin
            trial = ((SQ_IN_W'(st_reg[k-1].root) << (SQS - k + 1))
                     | (SQ_IN_W'(1) << (2 * (SQS - k)))) ;
            if (st_reg[k-1].rem >= trial)
            begin
                st_next[k].rem = st_reg[k-1].rem - trial;
                st_next[k].root = st_reg[k-1].root | (SQ_OUT_W'(1) << (SQS - k));
            end
        end
        // Seed stage.
        st_next[SQS+1].r = cordic_seed(st_reg[SQS].f.sinr, st_reg[SQS].f.cosr);
        st_next[SQS+1].p = cordic_seed(st_reg[SQS].f.sinp, SUM_W'(st_reg[SQS].root));
        st_next[SQS+1].yw = cordic_seed(st_reg[SQS].f.siny, st_reg[SQS].f.cosy);
        for (int i = 0; i < NSTEP; i++)
        begin
            st_next[SQS+2+i].r = cordic_iter(st_reg[SQS+1+i].r, i);
            st_next[SQS+2+i].p = cordic_iter(st_reg[SQS+1+i].p, i);
            st_next[SQS+2+i].yw = cordic_iter(st_reg[SQS+1+i].yw, i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
            st_reg[0] <= st_next[0];
        for (int k = 1; k < NST; k++)
            if (adv[k] && v_reg[k-1])
                st_reg[k] <= st_next[k];
    end

    logic signed [15:0] roll_w;
    logic signed [15:0] pitch_w;
    logic signed [15:0] yaw_w;
    logic signed [14:0] roll_reg;
    logic signed [13:0] pitch_reg;
    logic signed [14:0] yaw_reg;
    logic               clamped_reg;
    logic               ov_reg;

    assign roll_w = cordic_final(st_reg[NST-1].r, ROLL_YAW_LIMIT);
    assign pitch_w = cordic_final(st_reg[NST-1].p, PITCH_LIMIT);
    assign yaw_w = cordic_final(st_reg[NST-1].yw, ROLL_YAW_LIMIT);
    assign last_adv = !ov_reg || out_ready;

    // Output register after the last CORDIC stage.
    assign out_valid = ov_reg;
    assign roll = roll_reg;
    assign pitch = pitch_reg;
    assign yaw = yaw_reg;
    assign clamped = clamped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (last_adv)
            ov_reg <= v_reg[NST-1];
    end

    always_ff @(posedge clk)
    begin
        if (last_adv && v_reg[NST-1])
        begin
            roll_reg <= roll_w[14:0];
            pitch_reg <= pitch_w[13:0];
            yaw_reg <= yaw_w[14:0];
            clamped_reg <= st_reg[NST-1].f.clamped;
        end
    end

endmodule
